/* design/jac_pkg.sv */
// Shared types, widths and constants of the joystick axis conditioner.
package jac_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int AXIS_W     = 14;
    localparam int DZ_W       = 10;
    localparam int FILT_W     = 20;
    localparam int FRAC_W     = 8;

    // Calibration batch
    localparam int CAL_SAMPLES = 32;
    localparam int CAL_COUNT_W = 6;
    localparam int CAL_SUM_W   = 17;

    // Filter and map constants
    localparam int FULL_SCALE   = 4095;
    localparam int ALPHA_Q8     = 77;
    localparam int RESET_CENTER = 2048;
    localparam logic [FILT_W-1:0] FILT_MAX   = FILT_W'(FULL_SCALE << FRAC_W);
    localparam logic [FILT_W-1:0] FILT_HALF  = FILT_W'(1 << (FRAC_W - 1));
    localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(RESET_CENTER << FRAC_W);

    // Shared multiplier operand widths
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Serial divider: the quotient is known to fit in DIV_QUO_W bits
    localparam int DIV_DEN_W = 12;
    localparam int DIV_QUO_W = 14;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MID      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FIXED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_CENTER = 3'd5;

    // Register reset values
    localparam logic [DZ_W-1:0]          RST_DEADZONE     = 10'd64;
    localparam logic signed [AXIS_W-1:0] RST_OUT_LOW      = -14'sd4095;
    localparam logic signed [AXIS_W-1:0] RST_OUT_MID      = 14'sd0;
    localparam logic signed [AXIS_W-1:0] RST_OUT_HIGH     = 14'sd4095;
    localparam logic                     RST_USE_FIXED    = 1'b0;
    localparam logic [ADC_W-1:0]         RST_FIXED_CENTER = 12'd2000;

    typedef struct packed {
        logic [DZ_W-1:0]          deadzone;
        logic signed [AXIS_W-1:0] out_low;
        logic signed [AXIS_W-1:0] out_mid;
        logic signed [AXIS_W-1:0] out_high;
        logic                     use_fixed_center;
        logic [ADC_W-1:0]         fixed_center;
    } t_cfg;

endpackage

/* design/joystick_axis_conditioner.sv */
// Top level of the joystick axis conditioner: sequencer, filter and map datapath.
//
// Conditions one 12-bit joystick axis. Requests enter on i_in_valid / o_in_stall
// and carry i_operation and i_adc_sample; results leave on o_out_valid /
// i_out_stall as o_axis_value. A channel moves a request at an edge where valid
// is high and stall is low.
// A calibration request (operation 0) adds its sample to a running sum, gives no
// result and keeps the sequencer idle; the request that completes a batch of CAL_SAMPLES
// also loads the rest centre with the truncated average and reloads the filter.
// A read request (operation 1) runs the exponential filter through the shared
// multiplier, then maps the level. Inside the deadzone or past a scale edge the
// result goes straight to the hand-off; otherwise the map takes the multiplier
// once more and the 14-step serial divider. A new request waits until the last
// read is handed off. A finished result sits in the output register; if the
// receiver stalls, the next request is still accepted and runs up to the hand-off,
// where it waits. Configuration writes go through i_cfg_we / i_cfg_index /
// i_cfg_data; the user makes them only while idle, the block does not enforce it.
// Reset (synchronous, active low) restores register defaults, a filter at 2048.0,
// a rest centre of 2048, an empty calibration batch and an empty output.
module joystick_axis_conditioner import jac_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_operation,
    input  logic [ADC_W-1:0]         i_adc_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [AXIS_W-1:0] o_axis_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FILT_DIFF = 4'd1;
    localparam logic [3:0] S_FILT_MUL  = 4'd2;
    localparam logic [3:0] S_FILT_ADD  = 4'd3;
    localparam logic [3:0] S_LEVEL     = 4'd4;
    localparam logic [3:0] S_MAP_SETUP = 4'd5;
    localparam logic [3:0] S_MAP_MUL   = 4'd6;
    localparam logic [3:0] S_DIV_START = 4'd7;
    localparam logic [3:0] S_MAP_DIV   = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    t_cfg cfg;

    logic [3:0]                r_state;
    logic [ADC_W-1:0]          r_sample;
    logic [FILT_W-1:0]         r_filt;
    logic [ADC_W-1:0]          r_rest;
    logic [CAL_SUM_W-1:0]      r_sum;
    logic [CAL_COUNT_W-1:0]    r_count;
    logic [ADC_W-1:0]          r_level;
    logic signed [MUL_A_W-1:0] r_mul_a;
    logic signed [MUL_B_W-1:0] r_mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic [DIV_DEN_W-1:0]      r_den;
    logic signed [AXIS_W-1:0]  r_base;
    logic                      r_neg;
    logic signed [AXIS_W-1:0]  r_result;
    logic                      r_out_valid;
    logic signed [AXIS_W-1:0]  r_out_value;

    logic                      in_accept;
    logic                      out_free;

    // Calibration
    logic [CAL_SUM_W-1:0]      n_sum;
    logic [CAL_COUNT_W-1:0]    n_count;
    logic [ADC_W-1:0]          cal_avg;

    // Filter
    logic signed [FILT_W:0]    filt_diff;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  prod_shift;
    logic signed [MUL_A_W-1:0] filt_sum;
    logic [FILT_W-1:0]         n_filt;
    logic [FILT_W-1:0]         level_round;

    // Map
    logic [ADC_W-1:0]          centre;
    logic signed [ADC_W:0]     diff_s;
    logic signed [ADC_W:0]     diff_neg;
    logic [ADC_W-1:0]          abs_diff;
    logic                      in_zone;
    logic signed [ADC_W:0]     e_lo;
    logic [ADC_W:0]            e_hi;
    logic                      lo_side;
    logic                      lo_edge;
    logic                      hi_edge;
    logic signed [AXIS_W:0]    dl_lo;
    logic signed [AXIS_W:0]    dl_hi;

    // Divider hook-up
    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_dividend;
    logic [DIV_DEN_W-1:0]      div_divisor;
    logic                      div_done;
    logic [DIV_QUO_W-1:0]      div_quo;
    logic [PROD_W-1:0]         prod_mag;
    logic signed [AXIS_W:0]    quo_s;
    logic signed [AXIS_W+1:0]  map_sum;

    jac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // One input request at a time; the output register decouples the receiver.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Calibration running sum and count; the batch size is a power of two
    assign n_sum   = r_sum + CAL_SUM_W'(i_adc_sample);
    assign n_count = r_count + 1'b1;
    assign cal_avg = ADC_W'(n_sum / CAL_SUM_W'(CAL_SAMPLES));

    // Filter: d = sample.0 - filt, then filt += floor(77 * d / 256), clamped to scale
    assign filt_diff  = $signed({1'b0, r_sample, {FRAC_W{1'b0}}}) - $signed({1'b0, r_filt});
    assign mul_p      = r_mul_a * r_mul_b;
    assign prod_shift = r_prod >>> FRAC_W;
    assign filt_sum   = $signed({2'b00, r_filt}) + prod_shift[MUL_A_W-1:0];

    always_comb begin
        if (filt_sum < 0) begin
            n_filt = '0;
        end else if (filt_sum > $signed({2'b00, FILT_MAX})) begin
            n_filt = FILT_MAX;
        end else begin
            n_filt = filt_sum[FILT_W-1:0];
        end
    end

    // Round half-up to the integer level
    assign level_round = r_filt + FILT_HALF;

    // Map: deadzone test, scale-edge tests and the segment operands
    assign centre   = cfg.use_fixed_center ? cfg.fixed_center : r_rest;
    assign diff_s   = $signed({1'b0, r_level}) - $signed({1'b0, centre});
    assign diff_neg = -diff_s;
    assign abs_diff = diff_s[ADC_W] ? diff_neg[ADC_W-1:0] : diff_s[ADC_W-1:0];
    assign in_zone  = abs_diff < {{(ADC_W-DZ_W){1'b0}}, cfg.deadzone};
    assign lo_side  = diff_s[ADC_W];
    assign e_lo     = $signed({1'b0, centre}) - $signed({{(ADC_W-DZ_W+1){1'b0}}, cfg.deadzone});
    assign e_hi     = {1'b0, centre} + {{(ADC_W-DZ_W+1){1'b0}}, cfg.deadzone};
    assign lo_edge  = e_lo[ADC_W] || (e_lo == '0);
    assign hi_edge  = e_hi >= (ADC_W+1)'(FULL_SCALE);
    assign dl_lo    = {cfg.out_mid[AXIS_W-1], cfg.out_mid} - {cfg.out_low[AXIS_W-1], cfg.out_low};
    assign dl_hi    = {cfg.out_high[AXIS_W-1], cfg.out_high} - {cfg.out_mid[AXIS_W-1], cfg.out_mid};

    // Serial divider: segment scaling
    assign div_start    = (r_state == S_DIV_START);
    assign prod_mag     = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign div_dividend = prod_mag[DIV_NUM_W-1:0];
    assign div_divisor  = r_den;

    jac_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Truncate toward zero: divide magnitudes, then restore the sign
    assign quo_s   = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign map_sum = {{2{r_base[AXIS_W-1]}}, r_base} + {quo_s[AXIS_W], quo_s};

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_filt  <= FILT_RESET;
            r_rest  <= ADC_W'(RESET_CENTER);
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_operation) begin
                            r_state <= S_FILT_DIFF;
                        end else if (n_count >= CAL_COUNT_W'(CAL_SAMPLES)) begin
                            // batch complete: load centre and filter, start a new batch
                            r_rest  <= cal_avg;
                            r_filt  <= {cal_avg, {FRAC_W{1'b0}}};
                            r_sum   <= '0;
                            r_count <= '0;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= n_count;
                        end
                    end
                end
                S_FILT_DIFF: r_state <= S_FILT_MUL;
                S_FILT_MUL:  r_state <= S_FILT_ADD;
                S_FILT_ADD: begin
                    r_filt  <= n_filt;
                    r_state <= S_LEVEL;
                end
                S_LEVEL: r_state <= S_MAP_SETUP;
                S_MAP_SETUP: begin
                    // short-cut to out_mid inside the deadzone or past a scale edge
                    if (in_zone || (lo_side && lo_edge) || (!lo_side && hi_edge)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MAP_MUL;
                    end
                end
                S_MAP_MUL:   r_state <= S_DIV_START;
                S_DIV_START: r_state <= S_MAP_DIV;
                S_MAP_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_adc_sample;
        end
        case (r_state)
            S_FILT_DIFF: begin
                r_mul_a <= MUL_A_W'(filt_diff);
                r_mul_b <= MUL_B_W'(ALPHA_Q8);
            end
            S_FILT_MUL, S_MAP_MUL: begin
                r_prod <= mul_p;
            end
            S_LEVEL: begin
                r_level <= level_round[FILT_W-1:FRAC_W];
            end
            S_MAP_SETUP: begin
                r_result <= cfg.out_mid;
                if (lo_side) begin
                    r_mul_a <= $signed({{(MUL_A_W-ADC_W){1'b0}}, r_level});
                    r_mul_b <= MUL_B_W'(dl_lo);
                    r_den   <= e_lo[ADC_W-1:0];
                    r_base  <= cfg.out_low;
                end else begin
                    r_mul_a <= $signed({{(MUL_A_W-ADC_W){1'b0}}, r_level - e_hi[ADC_W-1:0]});
                    r_mul_b <= MUL_B_W'(dl_hi);
                    r_den   <= ADC_W'(FULL_SCALE) - e_hi[ADC_W-1:0];
                    r_base  <= cfg.out_mid;
                end
            end
            S_DIV_START: begin
                r_neg <= r_prod[PROD_W-1];
            end
            S_MAP_DIV: begin
                if (div_done) begin
                    r_result <= map_sum[AXIS_W-1:0];
                end
            end
            default: begin
                // hold
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_value <= r_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_axis_value = r_out_value;

    // The divider only finishes while the sequencer waits for it
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MAP_DIV))
        else $error("divider finished outside a wait state");

    // The filter never leaves the converter scale
    a_filt_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt <= FILT_MAX)
        else $error("filter level beyond full scale");

    // A batch never holds a full count while idle
    a_cal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < CAL_COUNT_W'(CAL_SAMPLES)))
        else $error("calibration count not cleared after a full batch");

    // A result handed to a free output register shows up as valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result lost at hand-off");

endmodule

/* design/jac_cfg_regs.sv */
// Configuration register file of the joystick axis conditioner.
module jac_cfg_regs import jac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone         <= RST_DEADZONE;
            r_cfg.out_low          <= RST_OUT_LOW;
            r_cfg.out_mid          <= RST_OUT_MID;
            r_cfg.out_high         <= RST_OUT_HIGH;
            r_cfg.use_fixed_center <= RST_USE_FIXED;
            r_cfg.fixed_center     <= RST_FIXED_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEADZONE:     r_cfg.deadzone         <= i_cfg_data[DZ_W-1:0];
                CFG_OUT_LOW:      r_cfg.out_low          <= $signed(i_cfg_data[AXIS_W-1:0]);
                CFG_OUT_MID:      r_cfg.out_mid          <= $signed(i_cfg_data[AXIS_W-1:0]);
                CFG_OUT_HIGH:     r_cfg.out_high         <= $signed(i_cfg_data[AXIS_W-1:0]);
                CFG_USE_FIXED:    r_cfg.use_fixed_center <= i_cfg_data[0];
                CFG_FIXED_CENTER: r_cfg.fixed_center     <= i_cfg_data[ADC_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/jac_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
module jac_divider import jac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_QUO_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_QUO_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   trial_sub;
    logic                 take;

    // The caller guarantees the upper dividend bits start below the divisor.
    assign trial     = {r_rem, r_quo[DIV_QUO_W-1]};
    assign take      = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIV_NUM_W-1 -: DIV_DEN_W];
            r_quo <= i_dividend[DIV_QUO_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_QUO_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
